/* design/instruction_execute_unit_defines.svh */
// Assertion macros for the instruction execute unit
`ifndef INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
// implication checked on every edge outside reset
`define IEU_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define IEU_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

/* design/ieu_pkg.sv */
// Package for the instruction execute unit: opcodes, fault codes, types
`timescale 1ns / 1ps
package ieu_pkg;
   localparam logic [1:0] FMT_REG = 2'b00;
   localparam logic [1:0] FMT_IMM = 2'b01;

   localparam logic [5:0] OP_MOV  = 6'h04;
   localparam logic [5:0] OP_ADD  = 6'h05;
   localparam logic [5:0] OP_SUB  = 6'h06;
   localparam logic [5:0] OP_MUL  = 6'h07;
   localparam logic [5:0] OP_DIV  = 6'h08;
   localparam logic [5:0] OP_AND  = 6'h09;
   localparam logic [5:0] OP_OR   = 6'h0A;
   localparam logic [5:0] OP_SLT  = 6'h10;
   localparam logic [5:0] OP_MOVI = 6'h0B;
   localparam logic [5:0] OP_ADDI = 6'h0C;
   localparam logic [5:0] OP_MULI = 6'h0D;
   localparam logic [5:0] OP_DIVI = 6'h0E;
   localparam logic [5:0] OP_LDI  = 6'h0F;
   localparam logic [5:0] OP_SLTI = 6'h11;
   localparam logic [5:0] OP_BEQ  = 6'h15;
   localparam logic [5:0] OP_BNE  = 6'h16;
   localparam logic [5:0] OP_BEZ  = 6'h17;
   localparam logic [5:0] OP_BNZ  = 6'h18;
   localparam logic [5:0] OP_BGZ  = 6'h19;
   localparam logic [5:0] OP_BLZ  = 6'h1A;
   localparam logic [5:0] OP_ST   = 6'h02;
   localparam logic [5:0] OP_LW   = 6'h03;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_DIV0  = 2'd1;
   localparam logic [1:0] FAULT_UNSUP = 2'd2;
   localparam logic [1:0] FAULT_ADDR  = 2'd3;

   typedef logic [1:0] fault_type;
endpackage

/* design/instruction_execute_unit.sv */
// Instruction execute unit: register file and data memory in synchronous RAMs
// Each instruction passes RD1 and RD2 (register-file reads), EXEC and DONE;
// LW adds MEM for the data-memory read, DIV/DIVI add the 32-step divider and DFIN.
// One instruction at a time, taken once the previous result has transferred or
// transfers in that cycle; DONE holds while the result is stalled.
// After reset a clearing pass zeroes every word of the data memory;
// no instruction is taken until it ends. Register valid bits and pc reset at once.
`timescale 1ns / 1ps
module instruction_execute_unit #(
   parameter int MEM_WORDS = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_instruction,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_next_pc,
   output logic                   rsp_branch_taken,
   output logic                   rsp_reg_written,
   output logic [3:0]             rsp_dest_index,
   output logic signed [31:0]     rsp_dest_value,
   output logic                   rsp_mem_written,
   output ieu_pkg::fault_type     rsp_fault
);
   import ieu_pkg::*;
`include "instruction_execute_unit_defines.svh"

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CW = $clog2(WORD_BITS + 1);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RD1   = 4'd2;
   localparam logic [3:0] ST_RD2   = 4'd3;
   localparam logic [3:0] ST_EXEC  = 4'd4;
   localparam logic [3:0] ST_MEM   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_DFIN  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [AW:0]           clr_ff, clr_in;
   logic [31:0]           ins_ff, ins_in;
   logic [15:0]           pc_ff, pc_in;
   logic [15:0]           reg_valid_ff, reg_valid_in;
   logic [WORD_BITS-1:0]  a_ff, a_in, b_ff, b_in, r1_ff, r1_in;

   // register file, two synchronous read ports; the second reads register 1 outside IDLE
   logic [WORD_BITS-1:0]  rf_mem [16];
   logic [WORD_BITS-1:0]  rf_q_ff, rf_q2_ff;
   logic [3:0]            rf_ra, rf_rb;
   logic                  rf_we;
   logic [3:0]            rf_wa;
   logic [WORD_BITS-1:0]  rf_wd;

   logic [WORD_BITS-1:0]  dm_mem [MEM_WORDS];
   logic [WORD_BITS-1:0]  dm_q_ff;
   logic                  dm_we;
   logic [AW-1:0]         dm_wa, dm_ra;
   logic [WORD_BITS-1:0]  dm_wd;

   // divider
   logic [WORD_BITS-1:0]  dq_ff, dq_in, dd_ff, dd_in;
   logic [WORD_BITS:0]    drem_ff, drem_in;
   logic [CW-1:0]         dcnt_ff, dcnt_in;
   logic                  dneg_ff, dneg_in;

   // result registers
   logic                  rv_ff, rv_in, tk_ff, tk_in, rw_ff, rw_in, mw_ff, mw_in;
   logic [3:0]            di_ff, di_in;
   logic [WORD_BITS-1:0]  dv_ff, dv_in;
   fault_type             ft_ff, ft_in;
   logic [15:0]           npc_ff, npc_in;

   logic [1:0]  fmt;
   logic [5:0]  op;
   logic [3:0]  ra, rb, rc;
   logic [15:0] imm;
   logic [WORD_BITS-1:0] immw, raw;
   logic [WORD_BITS-1:0] va, vb, vr1, rd_v, rbv;
   logic signed [WORD_BITS-1:0] sa, sb, sr1;
   logic addr_ok;
   logic [WORD_BITS:0] dtrial;

   assign fmt  = ins_ff[31:30];
   assign op   = ins_ff[29:24];
   assign ra   = ins_ff[23:20];
   assign rb   = ins_ff[19:16];
   assign rc   = ins_ff[15:12];
   assign imm  = ins_ff[15:0];
   assign immw = WORD_BITS'(imm);
   assign raw  = WORD_BITS'(ra);

   // reads of never-written registers give zero without a clearing pass
   assign va  = a_ff;
   assign vb  = b_ff;
   assign vr1 = r1_ff;
   assign sa  = a_ff;
   assign sb  = b_ff;
   assign sr1 = r1_ff;
   // format 1 naming: rd = r[rb field], rbv = r[ra field]
   assign rd_v = b_ff;
   assign rbv  = a_ff;

   always_comb begin
      if (fmt == FMT_IMM && op == OP_ST) addr_ok = !rd_v[WORD_BITS-1]
         && (rd_v < WORD_BITS'(MEM_WORDS));
      else addr_ok = !rbv[WORD_BITS-1] && (rbv < WORD_BITS'(MEM_WORDS));
   end

   assign dtrial = {drem_ff[WORD_BITS-1:0], dq_ff[WORD_BITS-1]} - {1'b0, dd_ff};

   always_comb begin
      rf_ra = ra;
      rf_rb = rb;
      unique case (state_ff)
         ST_IDLE: begin
            rf_ra = req_instruction[23:20];
            rf_rb = req_instruction[19:16];
         end
         default: begin
            rf_ra = ra;
            rf_rb = 4'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_wa] <= rf_wd;
      rf_q_ff  <= rf_mem[rf_ra];
      rf_q2_ff <= rf_mem[(state_ff == ST_IDLE) ? rf_rb : 4'd1];
   end

   always_ff @(posedge clock) begin
      if (dm_we) dm_mem[dm_wa] <= dm_wd;
      dm_q_ff <= dm_mem[dm_ra];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ins_in       = ins_ff;
      pc_in        = pc_ff;
      reg_valid_in = reg_valid_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r1_in        = r1_ff;
      dq_in        = dq_ff;
      dd_in        = dd_ff;
      drem_in      = drem_ff;
      dcnt_in      = dcnt_ff;
      dneg_in      = dneg_ff;
      rv_in        = rv_ff;
      tk_in        = tk_ff;
      rw_in        = rw_ff;
      mw_in        = mw_ff;
      di_in        = di_ff;
      dv_in        = dv_ff;
      ft_in        = ft_ff;
      npc_in       = npc_ff;
      rf_we        = 1'b0;
      rf_wa        = di_ff;
      rf_wd        = dv_ff;
      dm_we        = 1'b0;
      dm_wa        = clr_ff[AW-1:0];
      dm_wd        = '0;
      dm_ra        = rbv[AW-1:0];
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            dm_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEM_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // result registers are reused, so wait for the pending transfer
            if (req_valid && (!rv_ff || !rsp_stall)) begin
               ins_in = req_instruction;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            a_in = reg_valid_ff[ra] ? rf_q_ff : '0;
            b_in = reg_valid_ff[rb] ? rf_q2_ff : '0;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            r1_in = reg_valid_ff[1] ? rf_q2_ff : '0;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            npc_in = pc_ff + 16'd1;
            tk_in = 1'b0;
            rw_in = 1'b0;
            mw_in = 1'b0;
            di_in = 4'd0;
            dv_in = '0;
            ft_in = FAULT_NONE;
            state_in = ST_DONE;
            if (fmt == FMT_REG) begin
               rw_in = 1'b1;
               di_in = rc;
               unique case (op)
                  OP_MOV: begin di_in = ra; dv_in = vb; end
                  OP_ADD: dv_in = va + vb;
                  OP_SUB: dv_in = va - vb;
                  OP_MUL: dv_in = va * vb;
                  OP_DIV: begin
                     if (vb == '0) begin
                        rw_in = 1'b0;
                        di_in = 4'd0;
                        ft_in = FAULT_DIV0;
                     end else begin
                        dneg_in = va[WORD_BITS-1] ^ vb[WORD_BITS-1];
                        dq_in = va[WORD_BITS-1] ? -va : va;
                        dd_in = vb[WORD_BITS-1] ? -vb : vb;
                        drem_in = '0;
                        dcnt_in = CW'(WORD_BITS);
                        state_in = ST_DIV;
                     end
                  end
                  OP_AND: dv_in = WORD_BITS'(va != '0 && vb != '0);
                  OP_OR:  dv_in = WORD_BITS'(va != '0 || vb != '0);
                  OP_SLT: dv_in = WORD_BITS'(sa < sb);
                  default: begin
                     rw_in = 1'b0;
                     di_in = 4'd0;
                     ft_in = FAULT_UNSUP;
                  end
               endcase
            end else if (fmt == FMT_IMM) begin
               di_in = rb;
               unique case (op)
                  OP_MOVI: begin rw_in = 1'b1; dv_in = immw; end
                  OP_ADDI: begin
                     rw_in = 1'b1;
                     if (imm == 16'd4) dv_in = rd_v + 1'b1;
                     else if (imm == 16'd0) dv_in = rbv;
                     else dv_in = rd_v + immw;
                  end
                  OP_MULI: begin
                     rw_in = 1'b1;
                     dv_in = rd_v + WORD_BITS'(20'(ra) * 20'(imm));
                  end
                  OP_DIVI: begin
                     if (imm == 16'd0) begin
                        di_in = 4'd0;
                        ft_in = FAULT_DIV0;
                     end else begin
                        // quotient of a 4-bit value: nonzero only for imm <= 15
                        rw_in = 1'b1;
                        dneg_in = 1'b0;
                        dq_in = raw;
                        dd_in = immw;
                        drem_in = '0;
                        dcnt_in = CW'(WORD_BITS);
                        state_in = ST_DIV;
                     end
                  end
                  OP_LDI:  begin rw_in = 1'b1; dv_in = WORD_BITS'(imm[15:2]); end
                  OP_SLTI: begin
                     rw_in = 1'b1;
                     dv_in = WORD_BITS'(($signed(rbv) < $signed({1'b0, immw})));
                  end
                  OP_BEQ: tk_in = (rd_v == rbv);
                  OP_BNE: tk_in = (rd_v != rbv);
                  OP_BEZ: tk_in = (rd_v == vr1);
                  OP_BNZ: tk_in = (rd_v != vr1);
                  OP_BGZ: tk_in = ($signed(rd_v) > sr1);
                  OP_BLZ: tk_in = ($signed(rd_v) < sr1);
                  OP_ST: begin
                     di_in = 4'd0;
                     if (rb != 4'd0 && ra != 4'd0) begin
                        if (addr_ok) begin
                           dm_we = 1'b1;
                           dm_wa = rd_v[AW-1:0];
                           dm_wd = rbv;
                           mw_in = 1'b1;
                        end else ft_in = FAULT_ADDR;
                     end
                  end
                  OP_LW: begin
                     if (addr_ok) begin
                        rw_in = 1'b1;
                        state_in = ST_MEM;
                     end else begin
                        di_in = 4'd0;
                        ft_in = FAULT_ADDR;
                     end
                  end
                  default: begin
                     di_in = 4'd0;
                     ft_in = FAULT_UNSUP;
                  end
               endcase
               if (!rw_in) di_in = 4'd0;
               if (tk_in) npc_in = {2'b00, imm[15:2]};
            end else begin
               ft_in = FAULT_UNSUP;
            end
         end
         ST_MEM: begin
            // dm_ra held on the address since EXEC
            dv_in = dm_q_ff;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            // restoring divider, one quotient bit per cycle
            if (!dtrial[WORD_BITS]) begin
               drem_in = dtrial;
               dq_in = {dq_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               drem_in = {drem_ff[WORD_BITS-1:0], dq_ff[WORD_BITS-1]};
               dq_in = {dq_ff[WORD_BITS-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == CW'(1)) state_in = ST_DFIN;
         end
         ST_DFIN: begin
            if (fmt == FMT_IMM) dv_in = rd_v + dq_ff;
            else dv_in = dneg_ff ? -dq_ff : dq_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rf_we = rw_ff;
               if (rw_ff) reg_valid_in[di_ff] = 1'b1;
               pc_in = npc_ff;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         reg_valid_ff <= '0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         reg_valid_ff <= reg_valid_in;
         rv_ff        <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff  <= ins_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      r1_ff   <= r1_in;
      dq_ff   <= dq_in;
      dd_ff   <= dd_in;
      drem_ff <= drem_in;
      dcnt_ff <= dcnt_in;
      dneg_ff <= dneg_in;
      tk_ff   <= tk_in;
      rw_ff   <= rw_in;
      mw_ff   <= mw_in;
      di_ff   <= di_in;
      dv_ff   <= dv_in;
      ft_ff   <= ft_in;
      npc_ff  <= npc_in;
   end

   assign req_stall        = (state_ff != ST_IDLE) || (rv_ff && rsp_stall);
   assign rsp_valid        = rv_ff;
   assign rsp_next_pc      = npc_ff;
   assign rsp_branch_taken = tk_ff;
   assign rsp_reg_written  = rw_ff;
   assign rsp_dest_index   = di_ff;
   assign rsp_dest_value   = 32'(dv_ff);
   assign rsp_mem_written  = mw_ff;
   assign rsp_fault        = ft_ff;

   `IEU_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `IEU_ASSERT_IMP(a_wr_fault, clock, reset, rv_ff && rw_ff, ft_ff == FAULT_NONE)
   `IEU_ASSERT_IMP(a_taken_nowr, clock, reset, rv_ff && tk_ff, !rw_ff && !mw_ff)
   `IEU_ASSERT_NXT(a_done_valid, clock, reset, state_ff == ST_DONE && !rsp_stall, rv_ff)
endmodule

/* sim/instruction_execute_unit_tb.sv */
// Testbench for the instruction execute unit: directed and random programs, scoreboard check
`timescale 1ns / 1ps
module instruction_execute_unit_tb;
   import ieu_pkg::*;

   localparam int MEM_DEPTH   = 1024;
   localparam int WATCH_LIMIT = 6000;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        branch_taken;
      logic        reg_written;
      logic [3:0]  dest_index;
      logic [31:0] dest_value;
      logic        mem_written;
      fault_type   fault;
   } outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_instruction = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_next_pc;
   logic rsp_branch_taken, rsp_reg_written, rsp_mem_written;
   logic [3:0] rsp_dest_index;
   logic signed [31:0] rsp_dest_value;
   fault_type rsp_fault;

   logic [31:0] regs [16];
   logic [31:0] dmem [MEM_DEPTH];
   logic [15:0] pc;

   logic [31:0] instr_q [$];
   outcome_t    outcome_q [$];
   int  send_idle_pct = 11, recv_idle_pct = 76;
   bit  hold_send = 1'b0;
   bit  failed = 1'b0;
   bit  in_taken = 1'b0;
   int  quiet_cycles = 0;

   always #6 clock = ~clock;

   instruction_execute_unit uut (.*);

   // Execute one instruction against the model state; return the outcome
   function automatic outcome_t execute(input logic [31:0] ins);
      outcome_t o;
      logic [1:0]  fmt;
      logic [5:0]  op;
      logic [3:0]  ra, rb, rc;
      logic [15:0] imm;
      logic [31:0] a, b, rd, r1, dv;
      logic        wr, br, cond, mw;
      logic [3:0]  di;
      fault_type   flt;
      fmt = ins[31:30]; op = ins[29:24];
      ra = ins[23:20]; rb = ins[19:16]; rc = ins[15:12]; imm = ins[15:0];
      wr = 0; br = 0; cond = 0; mw = 0; di = 0; dv = 0; flt = FAULT_NONE;
      if (fmt == FMT_REG) begin
         a = regs[ra]; b = regs[rb];
         wr = 1; di = rc;
         case (op)
            OP_MOV: begin di = ra; dv = b; end
            OP_ADD: dv = a + b;
            OP_SUB: dv = a - b;
            OP_MUL: dv = a * b;
            OP_DIV: begin
               if (b == 0) begin wr = 0; flt = FAULT_DIV0; end
               else if (b == 32'hFFFF_FFFF) dv = -a;
               else dv = $signed(a) / $signed(b);
            end
            OP_AND: dv = (a != 0 && b != 0);
            OP_OR:  dv = (a != 0 || b != 0);
            OP_SLT: dv = ($signed(a) < $signed(b));
            default: begin wr = 0; flt = FAULT_UNSUP; end
         endcase
      end else if (fmt == FMT_IMM) begin
         rd = regs[rb]; b = regs[ra]; r1 = regs[1];
         di = rb;
         case (op)
            OP_MOVI: begin wr = 1; dv = imm; end
            OP_ADDI: begin
               wr = 1;
               if (imm == 4) dv = rd + 1;
               else if (imm == 0) dv = b;
               else dv = rd + imm;
            end
            OP_MULI: begin wr = 1; dv = rd + ra * imm; end
            OP_DIVI: begin
               if (imm == 0) flt = FAULT_DIV0;
               else begin wr = 1; dv = rd + 32'(ra) / 32'(imm); end
            end
            OP_LDI:  begin wr = 1; dv = imm >> 2; end
            OP_SLTI: begin wr = 1; dv = ($signed(b) < $signed({16'h0, imm})); end
            OP_BEQ: begin br = 1; cond = (rd == b); end
            OP_BNE: begin br = 1; cond = (rd != b); end
            OP_BEZ: begin br = 1; cond = (rd == r1); end
            OP_BNZ: begin br = 1; cond = (rd != r1); end
            OP_BGZ: begin br = 1; cond = ($signed(rd) > $signed(r1)); end
            OP_BLZ: begin br = 1; cond = ($signed(rd) < $signed(r1)); end
            OP_ST: begin
               if (rb != 0 && ra != 0) begin
                  if ($signed(rd) < 0 || $signed(rd) >= MEM_DEPTH) flt = FAULT_ADDR;
                  else begin dmem[rd] = b; mw = 1; end
               end
            end
            OP_LW: begin
               if ($signed(b) < 0 || $signed(b) >= MEM_DEPTH) flt = FAULT_ADDR;
               else begin wr = 1; dv = dmem[b]; end
            end
            default: flt = FAULT_UNSUP;
         endcase
      end else begin
         flt = FAULT_UNSUP;
      end
      o.branch_taken = br && cond;
      o.next_pc = o.branch_taken ? (imm >> 2) : pc + 16'd1;
      if (wr) regs[di] = dv;
      else begin di = 0; dv = 0; end
      pc = o.next_pc;
      o.reg_written = wr; o.dest_index = di; o.dest_value = dv;
      o.mem_written = mw; o.fault = flt;
      return o;
   endfunction

   function automatic logic [31:0] imm_ins(logic [5:0] op, logic [3:0] b, logic [3:0] d,
                                           logic [15:0] imm);
      return {FMT_IMM, op, b, d, imm};
   endfunction

   function automatic logic [31:0] reg_ins(logic [5:0] op, logic [3:0] sa, logic [3:0] sb,
                                           logic [3:0] dst, logic [11:0] low);
      return {FMT_REG, op, sa, sb, dst, low};
   endfunction

   // Random instruction, mostly valid ops, with small addresses that may run past the memory
   function automatic logic [31:0] random_instr();
      logic [5:0] reg_ops [8] = '{OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_SLT};
      logic [5:0] imm_ops [14] = '{OP_MOVI, OP_ADDI, OP_MULI, OP_DIVI, OP_LDI, OP_SLTI,
                                   OP_BEQ, OP_BNE, OP_BEZ, OP_BNZ, OP_BGZ, OP_BLZ,
                                   OP_ST, OP_LW};
      logic [31:0] w;
      int sel;
      w = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 5) return w;
      if (sel < 30) begin
         w[31:30] = FMT_REG; w[29:24] = reg_ops[$urandom_range(0, 7)];
      end else if (sel < 45) begin
         // set up a small address in a register for memory traffic
         w = imm_ins(OP_MOVI, 4'($urandom), 4'($urandom_range(1, 15)),
                     16'($urandom_range(0, MEM_DEPTH + 20)));
      end else begin
         w[31:30] = FMT_IMM; w[29:24] = imm_ops[$urandom_range(0, 13)];
         if ($urandom_range(0, 3) != 0) w[15:0] = 16'($urandom_range(0, 40));
      end
      return w;
   endfunction

   // Driver: in_taken records whether the last rising edge took the transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || in_taken) begin
            if (instr_q.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_instruction <= instr_q[0];
               outcome_q.push_back(execute(instr_q[0]));
               instr_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Monitor
   always @(posedge clock) begin
      outcome_t exp, got;
      if (!reset) begin
         in_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_next_pc, rsp_branch_taken, rsp_reg_written, rsp_dest_index,
                    rsp_dest_value, rsp_mem_written, rsp_fault};
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $realtime, got);
               failed = 1'b1;
            end else begin
               exp = outcome_q.pop_front();
               if (got !== exp) begin
                  $display("%0t: mismatch, expected pc=%h br=%b rw=%b idx=%h val=%h mw=%b f=%0d",
                           $realtime, exp.next_pc, exp.branch_taken, exp.reg_written,
                           exp.dest_index, exp.dest_value, exp.mem_written, exp.fault);
                  $display("%0t:          actual   pc=%h br=%b rw=%b idx=%h val=%h mw=%b f=%0d",
                           $realtime, got.next_pc, got.branch_taken, got.reg_written,
                           got.dest_index, got.dest_value, got.mem_written, got.fault);
                  failed = 1'b1;
               end
            end
         end
         // watchdog limit is well above the length of the reset clearing pass
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("instruction_execute_unit verification failed");
            $finish;
         end
      end
   end

   task automatic drain();
      wait (instr_q.size() == 0 && outcome_q.size() == 0);
      @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      for (int i = 0; i < MEM_DEPTH; i++) dmem[i] = '0;
      pc = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, special cases
      instr_q.push_back(imm_ins(OP_MOVI, 0, 2, 16'hFFFF));
      instr_q.push_back(imm_ins(OP_LDI, 0, 3, 16'hFFFF));
      instr_q.push_back(reg_ins(OP_MUL, 2, 2, 4, 12'hFFF));       // large product
      instr_q.push_back(reg_ins(OP_MUL, 4, 2, 4, 0));
      instr_q.push_back(imm_ins(OP_ADDI, 0, 5, 1));
      instr_q.push_back(reg_ins(OP_SUB, 0, 5, 6, 0));             // r6 = -1
      instr_q.push_back(imm_ins(OP_MOVI, 0, 7, 16'h8000));
      instr_q.push_back(reg_ins(OP_MUL, 7, 7, 7, 0));             // 2^30
      instr_q.push_back(reg_ins(OP_ADD, 7, 7, 7, 0));             // most negative
      instr_q.push_back(reg_ins(OP_DIV, 7, 6, 8, 0));             // wraps
      instr_q.push_back(reg_ins(OP_DIV, 7, 0, 9, 0));             // divide by zero
      instr_q.push_back(reg_ins(OP_DIV, 2, 6, 9, 0));
      instr_q.push_back(imm_ins(OP_DIVI, 15, 9, 0));
      instr_q.push_back(imm_ins(OP_DIVI, 15, 9, 2));
      instr_q.push_back(imm_ins(OP_MULI, 15, 9, 16'hFFFF));
      instr_q.push_back(imm_ins(OP_ADDI, 0, 9, 4));
      instr_q.push_back(imm_ins(OP_ADDI, 7, 10, 0));
      instr_q.push_back(reg_ins(OP_AND, 7, 0, 11, 0));
      instr_q.push_back(reg_ins(OP_OR, 7, 0, 11, 0));
      instr_q.push_back(reg_ins(OP_SLT, 7, 6, 12, 0));
      instr_q.push_back(reg_ins(OP_MOV, 13, 6, 0, 0));
      instr_q.push_back(imm_ins(OP_SLTI, 6, 12, 16'hFFFF));
      instr_q.push_back(imm_ins(OP_MOVI, 0, 1, 16'd1023));
      instr_q.push_back(imm_ins(OP_ST, 6, 1, 0));                  // top address
      instr_q.push_back(imm_ins(OP_ST, 0, 1, 0));                  // zero register: no-op
      instr_q.push_back(imm_ins(OP_ST, 6, 6, 0));                  // negative address
      instr_q.push_back(imm_ins(OP_LW, 1, 14, 0));
      instr_q.push_back(imm_ins(OP_LW, 2, 14, 0));                 // beyond memory
      instr_q.push_back(imm_ins(OP_BEQ, 1, 1, 16'hFFFF));
      instr_q.push_back(imm_ins(OP_BNE, 1, 1, 16'h0010));
      instr_q.push_back(imm_ins(OP_BEZ, 0, 1, 16'h0020));
      instr_q.push_back(imm_ins(OP_BNZ, 0, 6, 16'h0030));
      instr_q.push_back(imm_ins(OP_BGZ, 0, 2, 16'h0040));
      instr_q.push_back(imm_ins(OP_BLZ, 0, 6, 16'h0050));
      instr_q.push_back({2'b10, 30'h3FFFFFFF});
      instr_q.push_back({2'b11, 30'h0});
      instr_q.push_back({FMT_REG, 6'h3F, 24'h0});
      instr_q.push_back({FMT_IMM, 6'h00, 24'hFFFFFF});
      drain();

      // sender pauses until every expected result has come
      hold_send = 1'b1;
      for (int i = 0; i < 10; i++) instr_q.push_back(random_instr());
      hold_send = 1'b0;
      wait (outcome_q.size() > 0);
      hold_send = 1'b1;
      wait (outcome_q.size() == 0);
      hold_send = 1'b0;
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 76 : 0;
         recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 11 : 0;
         for (int i = 0; i < 360; i++) instr_q.push_back(random_instr());
         drain();
      end

      repeat (50) @(posedge clock);
      if (!failed)
         $display("instruction_execute_unit verification clean");
      else
         $display("instruction_execute_unit verification failed");
      $finish;
   end
endmodule

/* sim.f */
+incdir+design
design/ieu_pkg.sv
design/instruction_execute_unit.sv
sim/instruction_execute_unit_tb.sv
